>>> sv/lags_pkg.sv
// Shared types and constants for the life automaton grid step block.
// Used by the cell rule unit and the top level; no dependencies.
package lags_pkg;

    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int CNT_W      = 4;
    localparam int CMD_W      = 2;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ROW_COUNT     = 2'd0,
        REG_COL_COUNT     = 2'd1,
        REG_SURVIVE_COUNT = 2'd2,
        REG_BIRTH_COUNT   = 2'd3
    } t_reg_idx;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET    = 7'd50;
    localparam logic [CNT_W-1:0]  SURVIVE_RESET = 4'd2;
    localparam logic [CNT_W-1:0]  BIRTH_RESET   = 4'd3;

    // Three-by-three neighborhood; bit 0 is the left column, bit 2 the right.
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] dn;
    } t_window;

endpackage

>>> sv/lags_row_mem.sv
// Row-wide grid memory with one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
module lags_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/lags_cell_rule.sv
// Shared neighbor count and rule unit, evaluated once per cell of a generation.
// Depends on lags_pkg for the neighborhood type and count width.
module lags_cell_rule (
    input  lags_pkg::t_window                i_win,
    input  logic [lags_pkg::CNT_W-1:0]       i_survive,
    input  logic [lags_pkg::CNT_W-1:0]       i_birth,
    output logic                             o_next
);
    import lags_pkg::*;

    logic [CNT_W-1:0] w_count;

    always_comb begin
        w_count = CNT_W'(i_win.up[0]) + CNT_W'(i_win.up[1]) + CNT_W'(i_win.up[2])
                + CNT_W'(i_win.mid[0]) + CNT_W'(i_win.mid[2])
                + CNT_W'(i_win.dn[0]) + CNT_W'(i_win.dn[1]) + CNT_W'(i_win.dn[2]);
        if (w_count == i_survive) begin
            o_next = i_win.mid[1];
        end else if (w_count == i_birth) begin
            o_next = 1'b1;
        end else begin
            o_next = 1'b0;
        end
    end

endmodule

>>> sv/life_automaton_grid_step.sv
// Life automaton grid step, top level.
// The slave stream takes one command transaction at a time: tuser holds the
// command, tdata the row, column and value. The master stream returns exactly
// one transaction per command with the read cell and the range status.
// The user must write the configuration registers over the APB-style port only
// while idle; the block itself does not enforce this.
// An advance uses the single cell rule unit, evaluating one cell per cycle,
// plus one memory read and one row write-back per row.
// After reset the grid memory is cleared one row per cycle, and no command
// transaction is accepted until every row is cleared.
// A finished result sits in an output register; the next command is accepted
// while it waits, and a stalled receiver only holds the following result back.
// Reset returns the registers to 50 rows, 50 columns, survive 2 and birth 3.
// The grid is stored one row per memory word.
module life_automaton_grid_step #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: row[5:0], col[11:6], value[12], zero pad[15:13]
    input  logic [lags_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // tuser: cmd[1:0]
    input  logic [lags_pkg::CMD_W-1:0]           i_s_tuser,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: cell_res[0], status[1], zero pad[7:2]
    output logic [lags_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lags_pkg::APB_AW-1:0]          paddr,
    input  logic [lags_pkg::APB_DW-1:0]          pwdata,
    output logic [lags_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import lags_pkg::*;

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    typedef enum logic [9:0] {
        S_CLR       = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_CELL_RD   = 10'b00_0000_0100,
        S_CELL_UPD  = 10'b00_0000_1000,
        S_ADV_START = 10'b00_0001_0000,
        S_ADV_CUR   = 10'b00_0010_0000,
        S_ADV_NXT   = 10'b00_0100_0000,
        S_ADV_CELL  = 10'b00_1000_0000,
        S_ADV_WR    = 10'b01_0000_0000,
        S_RES       = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [SIZE_W-1:0] r_row_count, r_col_count;
    logic [CNT_W-1:0]  r_survive, r_birth;
    logic [RAW-1:0]    r_clr_cnt, n_clr_cnt;
    logic              r_clr_res, n_clr_res;
    logic [RAW-1:0]    r_row, n_row;
    logic [CAW-1:0]    r_col, n_col;
    logic [MAX_COLS-1:0] r_prev, n_prev, r_cur, n_cur, r_nxt, n_nxt, r_new, n_new;
    t_cmd              r_in_cmd, n_in_cmd;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic              r_in_value, n_in_value;
    logic              r_res_cell, n_res_cell, r_res_status, n_res_status;
    logic              r_m_tvalid, n_m_tvalid, r_m_cell, n_m_cell, r_m_status, n_m_status;

    logic [RCW-1:0]      w_eff_rows;
    logic [CCW-1:0]      w_eff_cols;
    logic                w_in_range, w_left_ok, w_right_ok, w_last_col, w_last_row, w_next_ok;
    logic [CAW-1:0]      w_cm1, w_cp1;
    t_window             w_win;
    logic                w_rule_next;
    logic                w_mem_we, w_mem_re;
    logic [RAW-1:0]      w_mem_waddr, w_mem_raddr;
    logic [MAX_COLS-1:0] w_mem_wdata, w_mem_rdata;
    logic                w_cfg_wr;
    t_reg_idx            w_reg_idx;
    t_cmd                w_cmd;

    lags_row_mem #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    lags_cell_rule u_rule (
        .i_win     (w_win),
        .i_survive (r_survive),
        .i_birth   (r_birth),
        .o_next    (w_rule_next)
    );

    assign w_eff_rows = (int'(r_row_count) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(r_row_count);
    assign w_eff_cols = (int'(r_col_count) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(r_col_count);
    assign w_cmd      = t_cmd'(i_s_tuser);
    assign w_in_range = (int'(i_s_tdata[5:0]) < int'(w_eff_rows))
                     && (int'(i_s_tdata[11:6]) < int'(w_eff_cols));

    assign w_cm1      = r_col - CAW'(1);
    assign w_cp1      = r_col + CAW'(1);
    assign w_left_ok  = (r_col != '0);
    assign w_right_ok = (CCW'(r_col) + CCW'(1)) < w_eff_cols;
    assign w_last_col = (CCW'(r_col) + CCW'(1)) == w_eff_cols;
    assign w_last_row = (RCW'(r_row) + RCW'(1)) == w_eff_rows;
    assign w_next_ok  = (RCW'(r_row) + RCW'(1)) < w_eff_rows;

    always_comb begin
        w_win.up  = {w_right_ok ? r_prev[w_cp1] : 1'b0, r_prev[r_col],
                     w_left_ok ? r_prev[w_cm1] : 1'b0};
        w_win.mid = {w_right_ok ? r_cur[w_cp1] : 1'b0, r_cur[r_col],
                     w_left_ok ? r_cur[w_cm1] : 1'b0};
        w_win.dn  = {w_right_ok ? r_nxt[w_cp1] : 1'b0, r_nxt[r_col],
                     w_left_ok ? r_nxt[w_cm1] : 1'b0};
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_row;
        w_mem_wdata = r_new;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_row;
        case (r_state)
            S_CLR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_cnt;
                w_mem_wdata = '0;
            end
            S_CELL_RD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = RAW'(r_in_row);
            end
            S_CELL_UPD: begin
                w_mem_we    = (r_in_cmd == CMD_WRITE);
                w_mem_waddr = RAW'(r_in_row);
                w_mem_wdata = w_mem_rdata;
                w_mem_wdata[CAW'(r_in_col)] = r_in_value;
            end
            S_ADV_START: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = '0;
            end
            S_ADV_CUR: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = r_row + RAW'(1);
            end
            S_ADV_WR: begin
                w_mem_we    = 1'b1;
                w_mem_re    = 1'b1;
                w_mem_raddr = r_row + RAW'(2);
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_clr_res    = r_clr_res;
        n_row        = r_row;
        n_col        = r_col;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_new        = r_new;
        n_in_cmd     = r_in_cmd;
        n_in_row     = r_in_row;
        n_in_col     = r_in_col;
        n_in_value   = r_in_value;
        n_res_cell   = r_res_cell;
        n_res_status = r_res_status;
        n_m_tvalid   = r_m_tvalid && !i_m_tready;
        n_m_cell     = r_m_cell;
        n_m_status   = r_m_status;
        case (r_state)
            S_CLR: begin
                n_clr_cnt = r_clr_cnt + RAW'(1);
                if (r_clr_cnt == RAW'(MAX_ROWS - 1)) begin
                    n_clr_cnt = '0;
                    n_state   = r_clr_res ? S_RES : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_in_cmd     = w_cmd;
                    n_in_row     = i_s_tdata[5:0];
                    n_in_col     = i_s_tdata[11:6];
                    n_in_value   = i_s_tdata[12];
                    n_res_cell   = 1'b0;
                    n_res_status = STATUS_DONE;
                    n_row        = '0;
                    case (w_cmd)
                        CMD_WRITE, CMD_READ: begin
                            if (w_in_range) begin
                                n_state = S_CELL_RD;
                            end else begin
                                n_res_status = STATUS_RANGE;
                                n_state      = S_RES;
                            end
                        end
                        CMD_ADVANCE: begin
                            if (w_eff_rows == '0 || w_eff_cols == '0) begin
                                n_state = S_RES;
                            end else begin
                                n_state = S_ADV_START;
                            end
                        end
                        CMD_CLEAR: begin
                            n_clr_res = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_CELL_RD: begin
                n_state = S_CELL_UPD;
            end
            S_CELL_UPD: begin
                if (r_in_cmd == CMD_READ) begin
                    n_res_cell = w_mem_rdata[CAW'(r_in_col)];
                end
                n_state = S_RES;
            end
            S_ADV_START: begin
                n_state = S_ADV_CUR;
            end
            S_ADV_CUR: begin
                n_cur   = w_mem_rdata;
                n_prev  = '0;
                n_state = S_ADV_NXT;
            end
            S_ADV_NXT: begin
                n_nxt   = w_next_ok ? w_mem_rdata : '0;
                n_new   = r_cur;
                n_col   = '0;
                n_state = S_ADV_CELL;
            end
            S_ADV_CELL: begin
                n_new[r_col] = w_rule_next;
                n_col = r_col + CAW'(1);
                if (w_last_col) begin
                    n_state = S_ADV_WR;
                end
            end
            S_ADV_WR: begin
                n_prev = r_cur;
                n_cur  = r_nxt;
                n_row  = r_row + RAW'(1);
                n_state = w_last_row ? S_RES : S_ADV_NXT;
            end
            S_RES: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_cell   = r_res_cell;
                    n_m_status = r_res_status;
                    n_clr_res  = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_clr_res   <= 1'b0;
            r_m_tvalid  <= 1'b0;
            r_row_count <= SIZE_RESET;
            r_col_count <= SIZE_RESET;
            r_survive   <= SURVIVE_RESET;
            r_birth     <= BIRTH_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_clr_res  <= n_clr_res;
            r_m_tvalid <= n_m_tvalid;
            if (w_cfg_wr) begin
                case (w_reg_idx)
                    REG_ROW_COUNT:     r_row_count <= pwdata[SIZE_W-1:0];
                    REG_COL_COUNT:     r_col_count <= pwdata[SIZE_W-1:0];
                    REG_SURVIVE_COUNT: r_survive   <= pwdata[CNT_W-1:0];
                    REG_BIRTH_COUNT:   r_birth     <= pwdata[CNT_W-1:0];
                    default:           r_birth     <= r_birth;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_col        <= n_col;
        r_prev       <= n_prev;
        r_cur        <= n_cur;
        r_nxt        <= n_nxt;
        r_new        <= n_new;
        r_in_cmd     <= n_in_cmd;
        r_in_row     <= n_in_row;
        r_in_col     <= n_in_col;
        r_in_value   <= n_in_value;
        r_res_cell   <= n_res_cell;
        r_res_status <= n_res_status;
        r_m_cell     <= n_m_cell;
        r_m_status   <= n_m_status;
    end

    always_comb begin
        case (w_reg_idx)
            REG_ROW_COUNT:     prdata = APB_DW'(r_row_count);
            REG_COL_COUNT:     prdata = APB_DW'(r_col_count);
            REG_SURVIVE_COUNT: prdata = APB_DW'(r_survive);
            REG_BIRTH_COUNT:   prdata = APB_DW'(r_birth);
            default:           prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, r_m_status, r_m_cell};

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLR))
        else $error("grid clear pass does not follow reset");

    a_col_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_CELL) |-> ((CCW'(r_col) < w_eff_cols) && (RCW'(r_row) < w_eff_rows)))
        else $error("cell sweep outside the active area");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_RES) |-> !w_mem_we)
        else $error("grid memory written while no command is in progress");

    a_last_row_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_WR && w_last_row) |=> (r_state == S_RES))
        else $error("advance did not finish after the last row");
`endif

endmodule
